// ===== design/sbpe_pkg.sv =====
package sbpe_pkg;

   // Field widths
   localparam int DATA_W        = 32;
   localparam int OUT_W         = 48;
   localparam int FRAC_BITS_DEF = 16;

   // Divider: divisor is at most six times a 32-bit epsilon
   localparam int DEN_W      = DATA_W + 3;
   localparam int DIV_STEP   = 2;
   localparam int DIV_STAGES = OUT_W / DIV_STEP;
   localparam int DIV_LAT    = DIV_STAGES + 1;

   // Register file
   localparam int                   CSR_IDX_W     = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_LIMIT     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_STIFFNESS = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_EPSILON   = 2'd2;

endpackage

// ===== design/sbpe_div.sv =====
module sbpe_div
   import sbpe_pkg::*;
#(
   parameter int NUM_W = 64
) (
   input  logic              clock,
   input  logic              advance,
   input  logic [NUM_W-1:0]  num,
   input  logic [DEN_W-1:0]  den,
   output logic [OUT_W-1:0]  quo
);

   localparam int HI_W = NUM_W - OUT_W;

   logic [DIV_STAGES:0][DEN_W-1:0] rem_ff, rem_in;
   logic [DIV_STAGES:0][DEN_W-1:0] den_ff, den_in;
   logic [DIV_STAGES:0][OUT_W-1:0] low_ff, low_in;
   logic [DIV_STAGES:0][OUT_W-1:0] quo_ff, quo_in;
   logic [DIV_STAGES:0]            ovf_ff, ovf_in;

   always_comb begin
      logic [DEN_W-1:0] r;
      logic [OUT_W-1:0] l;
      logic [OUT_W-1:0] q;
      logic [DEN_W:0]   trial;
      r     = '0;
      l     = '0;
      q     = '0;
      trial = '0;
      // quotient overflows the output exactly when the high part reaches the divisor
      ovf_in[0] = {{DEN_W{1'b0}}, num[NUM_W-1:OUT_W]} >= {{HI_W{1'b0}}, den};
      rem_in[0] = ovf_in[0] ? '0 : DEN_W'(num[NUM_W-1:OUT_W]);
      low_in[0] = num[OUT_W-1:0];
      quo_in[0] = '0;
      den_in[0] = den;
      for (int k = 1; k <= DIV_STAGES; k++) begin
         r = rem_ff[k-1];
         l = low_ff[k-1];
         q = quo_ff[k-1];
         for (int j = 0; j < DIV_STEP; j++) begin
            trial = {r, l[OUT_W-1]};
            l     = l << 1;
            if (trial >= {1'b0, den_ff[k-1]}) begin
               r = DEN_W'(trial - {1'b0, den_ff[k-1]});
               q = {q[OUT_W-2:0], 1'b1};
            end else begin
               r = trial[DEN_W-1:0];
               q = {q[OUT_W-2:0], 1'b0};
            end
         end
         rem_in[k] = r;
         low_in[k] = l;
         quo_in[k] = q;
         den_in[k] = den_ff[k-1];
         ovf_in[k] = ovf_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rem_ff <= rem_in;
         den_ff <= den_in;
         low_ff <= low_in;
         quo_ff <= quo_in;
         ovf_ff <= ovf_in;
      end
   end

   // saturate
   assign quo = ovf_ff[DIV_STAGES] ? '1 : quo_ff[DIV_STAGES];

endmodule

// ===== design/soft_barrier_penalty_eval.sv =====
// Soft one-sided barrier evaluator. Each word on req carries a signed fixed-point
// sample x; the block forms d = x - limit and returns one rsp word holding the
// penalty, its slope and its curvature as unsigned fixed-point values with
// FRAC_BITS fraction bits, each saturating at the 48-bit maximum. Above the
// barrier (d > 0) the penalty is the quadratic s*d^2/2 + s*e*d/2 + s*e^2/6; in
// the blend zone -e < d <= 0 it is the cubic s*(d+e)^3/(6e); below that all
// three results are zero. s is stiffness and e is epsilon, both set through the
// csr port, which must only be written while no sample is in flight. The unit
// is fully pipelined: it takes one sample every clock unless the output buffer
// is full. Seven stages form the operands with 32x32 partial products, then
// three dividers, each settling two quotient bits per stage, produce the three
// results in parallel. A two-word output buffer decouples the sides; req_tready
// drops only while both buffer words wait on rsp_tready, and then the whole
// pipeline holds.
module soft_barrier_penalty_eval
   import sbpe_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   // configuration writes
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [DATA_W-1:0]    csr_data,
   // samples
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [DATA_W-1:0]    req_tdata,   // [31:0] sample
   // results
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [3*OUT_W-1:0]   rsp_tdata    // [47:0] penalty, [95:48] slope,
                                             // [143:96] curvature
);

   typedef enum logic [1:0] {
      MODE_ZERO,
      MODE_QUAD,
      MODE_CUBIC
   } mode_type;

   localparam logic [DATA_W-1:0] STIFFNESS_RST = 32'h0001_0000;
   localparam logic [DATA_W-1:0] EPSILON_RST   = 32'h0001_0000;

   // penalty and slope divisors above the barrier: 1/6 and 1/2
   localparam logic [DEN_W-1:0] DIV_SIXTH = DEN_W'(6);
   localparam logic [DEN_W-1:0] DIV_HALF  = DEN_W'(2);
   localparam logic [DEN_W-1:0] DIV_ONE   = DEN_W'(1);

   localparam int X_W    = 2 * DATA_W;          // s or s*u
   localparam int YP_W   = 2 * DATA_W + 3;      // 3u^2+3eu+e^2 or u^2
   localparam int Y1_W   = DATA_W + 2;          // 2u+e or u
   localparam int ROWP_W = DATA_W + YP_W;
   localparam int ROWQ_W = DATA_W + Y1_W;
   localparam int PP_W   = X_W + YP_W;
   localparam int P1_W   = X_W + Y1_W;
   localparam int NP_W   = PP_W - 2 * FRAC_BITS;
   localparam int N1_W   = P1_W - FRAC_BITS;

   localparam int PIPE_STAGES = 7;
   localparam int LAT         = PIPE_STAGES + DIV_LAT;

   localparam int FIFO_DEPTH = 2;
   localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);
   localparam int PTR_W      = $clog2(FIFO_DEPTH);

   // ---------------------------------------------------------------- registers
   logic [DATA_W-1:0] limit_ff, stiff_ff, eps_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= '0;
         stiff_ff <= STIFFNESS_RST;
         eps_ff   <= EPSILON_RST;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_LIMIT:     limit_ff <= csr_data;
            CSR_STIFFNESS: stiff_ff <= csr_data;
            CSR_EPSILON:   eps_ff   <= csr_data;
            default: begin
               // drop writes to unmapped indexes
            end
         endcase
      end
   end

   // ---------------------------------------------------------- flow control
   logic                 adv;
   logic                 accept;
   logic                 push, pop;
   logic [LAT-1:0]       vld_ff, vld_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [PTR_W-1:0]     wr_ptr_ff, rd_ptr_ff;
   logic [FIFO_DEPTH-1:0][3*OUT_W-1:0] buf_ff;

   // Hold every stage while the output buffer is full; otherwise advance all.
   assign adv        = (cnt_ff != CNT_W'(FIFO_DEPTH));
   assign req_tready = adv;
   assign accept     = req_tvalid && adv;
   assign push       = adv && vld_ff[LAT-1];
   assign pop        = rsp_tvalid && rsp_tready;
   assign vld_in     = {vld_ff[LAT-2:0], accept};
   assign cnt_in     = cnt_ff + CNT_W'(push) - CNT_W'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff    <= '0;
         cnt_ff    <= '0;
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
      end else begin
         if (adv) begin
            vld_ff <= vld_in;
         end
         cnt_ff <= cnt_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
   end

   // ------------------------------------------------------------ datapath
   // Stage 1: distance past the barrier, 33 bits, no wrap
   logic [DATA_W:0] d1_ff, d1_in;
   assign d1_in = {req_tdata[DATA_W-1], req_tdata} - {limit_ff[DATA_W-1], limit_ff};

   // Stage 2: pick the zone; u is d above the barrier, t = d + e in the blend
   mode_type          mode2_ff, mode2_in;
   logic [DATA_W-1:0] u2_ff, u2_in;
   logic [DATA_W+1:0] t2;
   logic              pos2, zone2;

   always_comb begin
      t2    = {d1_ff[DATA_W], d1_ff} + {2'b00, eps_ff};
      pos2  = !d1_ff[DATA_W] && (d1_ff != '0);
      zone2 = !t2[DATA_W+1] && (t2 != '0);
      if (pos2) begin
         mode2_in = MODE_QUAD;
         u2_in    = d1_ff[DATA_W-1:0];
      end else begin
         mode2_in = zone2 ? MODE_CUBIC : MODE_ZERO;
         u2_in    = t2[DATA_W-1:0];
      end
   end

   // Stage 3: first products, each a single 32x32 multiply
   mode_type          mode3_ff;
   logic [DATA_W-1:0] u3_ff;
   logic [X_W-1:0]    sq3_ff, sq3_in, eu3_ff, eu3_in, ee3_ff, ee3_in, su3_ff, su3_in;
   logic [Y1_W-1:0]   lin3_ff, lin3_in;

   assign sq3_in  = u2_ff * u2_ff;
   assign eu3_in  = eps_ff * u2_ff;
   assign ee3_in  = eps_ff * eps_ff;
   assign su3_in  = stiff_ff * u2_ff;
   assign lin3_in = (Y1_W'(u2_ff) << 1) + Y1_W'(eps_ff);

   // Stage 4: select the multiplier operands of each result
   mode_type        mode4_ff;
   logic [X_W-1:0]  x4_ff, x4_in, n24_ff, n24_in;
   logic [YP_W-1:0] yp4_ff, yp4_in;
   logic [Y1_W-1:0] y14_ff, y14_in;

   always_comb begin
      logic [YP_W-1:0] sum4;
      logic [YP_W-1:0] poly4;
      sum4  = YP_W'(sq3_ff) + YP_W'(eu3_ff);
      poly4 = sum4 + (sum4 << 1) + YP_W'(ee3_ff);
      if (mode3_ff == MODE_QUAD) begin
         x4_in  = X_W'(stiff_ff);
         yp4_in = poly4;
         y14_in = lin3_ff;
         n24_in = X_W'(stiff_ff);
      end else begin
         x4_in  = su3_ff;
         yp4_in = YP_W'(sq3_ff);
         y14_in = Y1_W'(u3_ff);
         n24_in = (mode3_ff == MODE_CUBIC) ? su3_ff : '0;
      end
   end

   // Stage 5: 32x32 partial products
   mode_type                       mode5_ff;
   logic [X_W-1:0]                 n25_ff;
   logic [1:0][2:0][X_W-1:0]       pp5_ff, pp5_in;
   logic [1:0][1:0][X_W-1:0]       qq5_ff, qq5_in;

   always_comb begin
      logic [1:0][DATA_W-1:0] xs;
      logic [2:0][DATA_W-1:0] ys;
      logic [1:0][DATA_W-1:0] zs;
      xs    = x4_ff;
      ys[0] = yp4_ff[DATA_W-1:0];
      ys[1] = yp4_ff[2*DATA_W-1:DATA_W];
      ys[2] = DATA_W'(yp4_ff[YP_W-1:2*DATA_W]);
      zs[0] = y14_ff[DATA_W-1:0];
      zs[1] = DATA_W'(y14_ff[Y1_W-1:DATA_W]);
      for (int i = 0; i < 2; i++) begin
         for (int j = 0; j < 3; j++) begin
            pp5_in[i][j] = xs[i] * ys[j];
         end
         for (int j = 0; j < 2; j++) begin
            qq5_in[i][j] = xs[i] * zs[j];
         end
      end
   end

   // Stage 6: sum each row of partials
   mode_type                  mode6_ff;
   logic [X_W-1:0]            n26_ff;
   logic [1:0][ROWP_W-1:0]    rowp6_ff, rowp6_in;
   logic [1:0][ROWQ_W-1:0]    rowq6_ff, rowq6_in;

   always_comb begin
      for (int i = 0; i < 2; i++) begin
         rowp6_in[i] = ROWP_W'(pp5_ff[i][0]) + (ROWP_W'(pp5_ff[i][1]) << DATA_W)
                     + (ROWP_W'(pp5_ff[i][2]) << (2 * DATA_W));
         rowq6_in[i] = ROWQ_W'(qq5_ff[i][0]) + (ROWQ_W'(qq5_ff[i][1]) << DATA_W);
      end
   end

   // Stage 7: full products
   mode_type         mode7_ff;
   logic [X_W-1:0]   n27_ff;
   logic [PP_W-1:0]  prodp7_ff, prodp7_in;
   logic [P1_W-1:0]  prod17_ff, prod17_in;

   assign prodp7_in = PP_W'(rowp6_ff[0]) + (PP_W'(rowp6_ff[1]) << DATA_W);
   assign prod17_in = P1_W'(rowq6_ff[0]) + (P1_W'(rowq6_ff[1]) << DATA_W);

   always_ff @(posedge clock) begin
      if (adv) begin
         d1_ff     <= d1_in;
         mode2_ff  <= mode2_in;
         u2_ff     <= u2_in;
         mode3_ff  <= mode2_ff;
         u3_ff     <= u2_ff;
         sq3_ff    <= sq3_in;
         eu3_ff    <= eu3_in;
         ee3_ff    <= ee3_in;
         su3_ff    <= su3_in;
         lin3_ff   <= lin3_in;
         mode4_ff  <= mode3_ff;
         x4_ff     <= x4_in;
         yp4_ff    <= yp4_in;
         y14_ff    <= y14_in;
         n24_ff    <= n24_in;
         mode5_ff  <= mode4_ff;
         n25_ff    <= n24_ff;
         pp5_ff    <= pp5_in;
         qq5_ff    <= qq5_in;
         mode6_ff  <= mode5_ff;
         n26_ff    <= n25_ff;
         rowp6_ff  <= rowp6_in;
         rowq6_ff  <= rowq6_in;
         mode7_ff  <= mode6_ff;
         n27_ff    <= n26_ff;
         prodp7_ff <= prodp7_in;
         prod17_ff <= prod17_in;
      end
   end

   // Scale by the fraction bits and pick the divisors of the zone
   logic [NP_W-1:0]  num_p;
   logic [N1_W-1:0]  num_1;
   logic [DEN_W-1:0] den_p, den_1, den_2;
   logic [DEN_W-1:0] eps_w;

   always_comb begin
      eps_w = DEN_W'(eps_ff);
      num_p = (mode7_ff == MODE_ZERO) ? '0 : NP_W'(prodp7_ff >> (2 * FRAC_BITS));
      num_1 = (mode7_ff == MODE_ZERO) ? '0 : N1_W'(prod17_ff >> FRAC_BITS);
      case (mode7_ff)
         MODE_QUAD: begin
            den_p = DIV_SIXTH;
            den_1 = DIV_HALF;
            den_2 = DIV_ONE;
         end
         MODE_CUBIC: begin
            den_p = (eps_w << 2) + (eps_w << 1);
            den_1 = eps_w << 1;
            den_2 = eps_w;
         end
         default: begin
            den_p = DIV_ONE;
            den_1 = DIV_ONE;
            den_2 = DIV_ONE;
         end
      endcase
   end

   logic [OUT_W-1:0] penalty, slope, curvature;

   sbpe_div #(.NUM_W(NP_W)) u_div_penalty (
      .clock   (clock),
      .advance (adv),
      .num     (num_p),
      .den     (den_p),
      .quo     (penalty)
   );

   sbpe_div #(.NUM_W(N1_W)) u_div_slope (
      .clock   (clock),
      .advance (adv),
      .num     (num_1),
      .den     (den_1),
      .quo     (slope)
   );

   sbpe_div #(.NUM_W(X_W)) u_div_curv (
      .clock   (clock),
      .advance (adv),
      .num     (n27_ff),
      .den     (den_2),
      .quo     (curvature)
   );

   // ---------------------------------------------------------- output buffer
   always_ff @(posedge clock) begin
      if (push) begin
         buf_ff[wr_ptr_ff] <= {curvature, slope, penalty};
      end
   end

   assign rsp_tvalid = (cnt_ff != '0);
   assign rsp_tdata  = buf_ff[rd_ptr_ff];

   // ------------------------------------------------------------ assertions
   a_stall_has_waiting_word: assert property (
      @(posedge clock) disable iff (reset) !req_tready |-> rsp_tvalid)
      else $error("input stalled with no result waiting");

   a_finished_word_reaches_output: assert property (
      @(posedge clock) disable iff (reset) (vld_ff[LAT-1] && adv) |=> rsp_tvalid)
      else $error("finished result did not reach the output");

   a_blend_zone_nonempty: assert property (
      @(posedge clock) disable iff (reset)
      (vld_ff[1] && mode2_ff == MODE_CUBIC) |-> (eps_ff != '0))
      else $error("blend zone chosen with zero epsilon");

endmodule

// ===== dv/soft_barrier_penalty_eval_checker.sv =====
`timescale 1ns / 100ps

module soft_barrier_penalty_eval_checker
   import sbpe_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_valid,
   input  logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [DATA_W-1:0]    csr_data,
   input  logic                 req_tvalid,
   input  logic                 req_tready,
   input  logic [DATA_W-1:0]    req_tdata,
   input  logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   input  logic [3*OUT_W-1:0]   rsp_tdata,
   output int                   fail_count,
   output int                   pending
);

   localparam int                MAX_REPORTS = 10;
   localparam logic [DATA_W-1:0] UNITY       = 32'h0001_0000;
   localparam logic [OUT_W-1:0]  OUT_MAX     = '1;

   // penalty sits in the low bits, matching rsp_tdata
   typedef struct packed {
      logic [OUT_W-1:0] curvature;
      logic [OUT_W-1:0] slope;
      logic [OUT_W-1:0] penalty;
   } barrier_result_type;

   logic [DATA_W-1:0]  barrier_limit;
   logic [DATA_W-1:0]  stiffness_gain;
   logic [DATA_W-1:0]  blend_width;
   barrier_result_type penalty_q[$];
   int                 word_count;

   function automatic logic [OUT_W-1:0] clip48(input logic [159:0] v);
      return (|v[159:OUT_W]) ? OUT_MAX : v[OUT_W-1:0];
   endfunction

   // Exact evaluation in wide unsigned integers, floor, then saturate.
   function automatic barrier_result_type barrier_eval(input logic [DATA_W-1:0] x);
      logic signed [34:0] overshoot;
      logic signed [34:0] blend_pos;
      logic [159:0]       s;
      logic [159:0]       e;
      logic [159:0]       d;
      logic [159:0]       t;
      logic [159:0]       st;
      logic [159:0]       stt;
      barrier_result_type r;
      s = {128'b0, stiffness_gain};
      e = {128'b0, blend_width};
      overshoot = $signed({{3{x[DATA_W-1]}}, x})
                - $signed({{3{barrier_limit[DATA_W-1]}}, barrier_limit});
      blend_pos = overshoot + $signed({3'b000, blend_width});
      r = '0;
      if (overshoot > 0) begin
         // quadratic side: s*(3d^2 + 3ed + e^2)/6 and s*(2d + e)/2
         d = {125'b0, overshoot};
         r.penalty   = clip48(((s * (3 * d * d + 3 * e * d + e * e)) >> (2 * FRAC_BITS)) / 6);
         r.slope     = clip48(((s * (2 * d + e)) >> FRAC_BITS) / 2);
         r.curvature = {{(OUT_W - DATA_W){1'b0}}, stiffness_gain};
      end else if (blend_pos > 0) begin
         // cubic blend in t = d + e
         t   = {125'b0, blend_pos};
         st  = s * t;
         stt = st * t;
         r.penalty   = clip48(((stt * t) >> (2 * FRAC_BITS)) / (6 * e));
         r.slope     = clip48((stt >> FRAC_BITS) / (2 * e));
         r.curvature = clip48(st / e);
      end
      return r;
   endfunction

   always @(posedge clock) begin
      barrier_result_type seen;
      barrier_result_type want;
      if (reset) begin
         barrier_limit  = '0;
         stiffness_gain = UNITY;
         blend_width    = UNITY;
         penalty_q.delete();
         pending    = 0;
         fail_count = 0;
         word_count = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_LIMIT:     barrier_limit  = csr_data;
               CSR_STIFFNESS: stiffness_gain = csr_data;
               CSR_EPSILON:   blend_width    = csr_data;
               default:       ;
            endcase
         end
         // retire before queueing: a result never belongs to a word taken this edge
         if (rsp_tvalid && rsp_tready) begin
            seen = rsp_tdata;
            if (penalty_q.size() == 0) begin
               fail_count++;
               if (fail_count <= MAX_REPORTS)
                  $display("result word %0d arrived with nothing pending: %h",
                           word_count, seen);
            end else begin
               want = penalty_q.pop_front();
               if (seen.penalty != want.penalty || seen.slope != want.slope ||
                   seen.curvature != want.curvature) begin
                  fail_count++;
                  if (fail_count <= MAX_REPORTS)
                     $display("result word %0d: penalty %h/%h slope %h/%h curvature %h/%h",
                              word_count, want.penalty, seen.penalty, want.slope,
                              seen.slope, want.curvature, seen.curvature);
               end
            end
            word_count++;
         end
         if (req_tvalid && req_tready)
            penalty_q.push_back(barrier_eval(req_tdata));
         pending = penalty_q.size();
      end
   end

endmodule

// ===== dv/soft_barrier_penalty_eval_tb.sv =====
`timescale 1ns / 100ps

module soft_barrier_penalty_eval_tb
   import sbpe_pkg::*;
();

   localparam int                LIMIT_CYCLES    = 200000;
   localparam int                RANDOM_PHASES   = 6;
   localparam int                PHASE_WORDS     = 155;
   localparam int                HOLD_OFF_CYCLES = 200;
   // pipeline is 32 deep plus the output buffer; leave a margin
   localparam int                DRAIN_CYCLES    = DIV_LAT + 15;
   localparam logic [DATA_W-1:0] UNITY           = 32'h0001_0000;
   localparam logic [DATA_W-1:0] POS_MAX         = 32'h7FFF_FFFF;
   localparam logic [DATA_W-1:0] NEG_MAX         = 32'h8000_0000;
   localparam logic [DATA_W-1:0] ALL_ONES        = 32'hFFFF_FFFF;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = CSR_LIMIT;
   logic [DATA_W-1:0]    csr_data = '0;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [DATA_W-1:0]    req_tdata = '0;      // [31:0] sample
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [3*OUT_W-1:0]   rsp_tdata;           // [47:0] penalty, [95:48] slope,
                                              // [143:96] curvature
   int                   fail_count;
   int                   pending;
   int                   cycle_count;
   bit                   req_burst = 1'b0;
   bit                   rsp_burst = 1'b0;
   bit                   hold_off_req = 1'b0;
   // stimulus-side copy of the barrier setup, used to aim samples at the zones
   logic [DATA_W-1:0]    cur_limit = '0;
   logic [DATA_W-1:0]    cur_epsilon = UNITY;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   soft_barrier_penalty_eval DUT (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   soft_barrier_penalty_eval_checker checker_i (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .fail_count (fail_count),
      .pending    (pending)
   );

   // Hold one register write until the block takes it; enter and leave on a falling edge.
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
      csr_index = idx;
      csr_data  = val;
      csr_valid = 1'b1;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
   endtask

   task automatic configure(input logic [DATA_W-1:0] lim, input logic [DATA_W-1:0] stiff,
                            input logic [DATA_W-1:0] eps);
      write_reg(CSR_LIMIT, lim);
      write_reg(CSR_STIFFNESS, stiff);
      write_reg(CSR_EPSILON, eps);
      csr_valid   = 1'b0;
      cur_limit   = lim;
      cur_epsilon = eps;
   endtask

   // Offer one sample word after a random gap; valid stays up across back-to-back words.
   task automatic push_sample(input logic [DATA_W-1:0] x);
      int gap;
      gap = req_burst ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tdata  = x;
      req_tvalid = 1'b1;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   // Drop valid and wait until every predicted result has come back.
   task automatic drain();
      req_tvalid = 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // Aim at the zone boundaries and the blend zone around the current limit.
   function automatic logic [DATA_W-1:0] random_sample();
      longint lim;
      longint eps;
      longint off;
      lim = longint'($signed(cur_limit));
      eps = longint'(cur_epsilon);
      case ($urandom_range(0, 11))
         0:       off = -eps;
         1:       off = -eps + 1;
         2:       off = 0;
         3:       off = 1;
         4, 5, 6: off = longint'({$urandom, $urandom} % (2 * eps + 1)) - eps;
         7:       off = longint'($urandom_range(0, 4095)) - 2048;
         8:       off = longint'($urandom_range(0, 32'h0010_0000));
         9:       return (($urandom_range(0, 1) == 0) ? POS_MAX : NEG_MAX);
         default: return $urandom;
      endcase
      return DATA_W'(lim + off);
   endfunction

   // Sink: random stall before each word, bursts with no stall, one long hold-off on request.
   initial begin
      int stall;
      int words;
      bit held;
      words = 0;
      held  = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (words % 48 == 0)
            rsp_burst = ($urandom_range(0, 3) == 0);
         stall = rsp_burst ? 0 : $urandom_range(0, 7);
         if (hold_off_req && !held) begin
            // long hold-off: the output buffer and the pipeline fill and req stalls
            held  = 1'b1;
            stall = HOLD_OFF_CYCLES;
         end
         if (stall > 0) begin
            rsp_tready = 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready = 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         words++;
         @(negedge clock);
      end
   end

   // Watchdog: a run that never finishes counts as a failure.
   initial begin
      cycle_count = 0;
      while (cycle_count < LIMIT_CYCLES) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Regression FAIL");
      $finish;
   end

   initial begin
      logic [DATA_W-1:0] lim;
      logic [DATA_W-1:0] stiff;
      logic [DATA_W-1:0] eps;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // unit stiffness and width: both zone edges, tiny offsets, sample extremes
      configure('0, UNITY, UNITY);
      push_sample('0);
      push_sample(32'h0000_0001);
      push_sample(ALL_ONES);
      push_sample(32'hFFFF_0000);
      push_sample(32'hFFFF_0001);
      push_sample(UNITY);
      push_sample(32'hFFFF_8000);
      push_sample(POS_MAX);
      push_sample(NEG_MAX);
      drain();

      // lowest limit, largest gain and width: widest overshoot saturates
      configure(NEG_MAX, ALL_ONES, ALL_ONES);
      push_sample(POS_MAX);
      push_sample(NEG_MAX);
      push_sample(32'h8000_0001);
      push_sample('0);
      drain();

      // highest limit, zero gain, narrowest blend zone
      configure(POS_MAX, '0, 32'h0000_0001);
      push_sample(POS_MAX);
      push_sample(32'h7FFF_FFFE);
      push_sample(NEG_MAX);
      drain();

      // widest blend zone reaching all the way down from the top
      configure(POS_MAX, ALL_ONES, ALL_ONES);
      push_sample(NEG_MAX);
      push_sample(32'h8000_0001);
      push_sample(POS_MAX);
      push_sample('0);
      drain();

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         lim = (p % 2 == 0) ? $urandom : DATA_W'($urandom_range(0, 32'h0010_0000) - 32'h0008_0000);
         case (p % 3)
            0: begin
               stiff = $urandom;
               eps   = $urandom_range(1, 32'h0008_0000);
            end
            1: begin
               stiff = $urandom_range(0, 32'h0004_0000);
               eps   = $urandom_range(1, ALL_ONES);
            end
            default: begin
               stiff = UNITY + $urandom_range(0, 32'h0000_FFFF);
               eps   = $urandom_range(1, 64);
            end
         endcase
         configure(lim, stiff, eps);
         if (p == 2)
            hold_off_req = 1'b1;
         for (int i = 0; i < PHASE_WORDS; i++) begin
            if (i % 40 == 0)
               req_burst = ($urandom_range(0, 3) == 0);
            push_sample(random_sample());
         end
         req_burst = 1'b0;
         drain();
      end

      if (fail_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
